>>> sv/mpk_pkg.sv
// shared constants, codes and controller/datapath interface types for the paddle keyer
// no dependencies
package mpk_pkg;

    localparam int POT_W        = 10;
    localparam int POT_BITS_DEF = 10;
    localparam int WPM_W        = 6;
    localparam int TICK_W       = 13;
    localparam int UNIT_W       = 10;
    localparam int CFG_IDX_W    = 1;

    localparam int UNIT_NUM     = 60000;
    localparam int WPM_FACTOR   = 73;
    localparam int DOT_UNITS    = 2;
    localparam int DASH_UNITS   = 6;
    localparam int WPM_MAX      = (1 << WPM_W) - 1;

    localparam logic [WPM_W-1:0] RST_MAX_WPM = WPM_W'(30);
    localparam logic [WPM_W-1:0] RST_MIN_WPM = WPM_W'(3);

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WPM = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WPM = CFG_IDX_W'(1);

    typedef enum logic [2:0] {
        TK_HOLD,
        TK_LOAD_DOT,
        TK_LOAD_DASH,
        TK_LOAD_UNIT,
        TK_DEC
    } t_tick_op;

    typedef enum logic [1:0] {
        TN_HOLD,
        TN_CLEAR,
        TN_TOGGLE
    } t_tone_op;

    typedef struct packed {
        logic     in_latch;
        logic     map_start;
        logic     unit_start;
        logic     unit_latch;
        t_tick_op tick_op;
        t_tone_op tone_op;
        logic     out_load;
        logic     out_key;
    } t_dp_cmd;

    typedef struct packed {
        logic dot;
        logic dash;
        logic ticks_zero;
        logic ticks_one;
        logic div_done;
        logic out_free;
    } t_dp_stat;

endpackage

>>> sv/mpk_div.sv
// bit-serial restoring divider, one quotient bit per cycle
// depends on nothing but its parameters
module mpk_div #(
    parameter int NUM_W = 16,
    parameter int DEN_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic             o_done,
    output logic [NUM_W-1:0] o_quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DEN_W-1:0] r_rem;
    logic [NUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_den;

    logic [DEN_W:0]   rem_sh;
    logic             ge;
    logic [DEN_W:0]   rem_nx;

    always_comb begin
        rem_sh = {r_rem, r_quo[NUM_W-1]};
        ge     = rem_sh >= {1'b0, r_den};
        rem_nx = ge ? rem_sh - {1'b0, r_den} : rem_sh;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= rem_nx[DEN_W-1:0];
            r_quo <= {r_quo[NUM_W-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

>>> sv/mpk_dp.sv
// keyer datapath: speed registers, unit computation, tick counter, sidetone, result register
// depends on mpk_pkg and mpk_div
module mpk_dp
    import mpk_pkg::*;
#(
    parameter int POT_BITS = POT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WPM_W-1:0]     i_cfg_data,
    input  logic                 i_dot_lever_n,
    input  logic                 i_dash_lever_n,
    input  logic [POT_W-1:0]     i_pot_sample,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic                 o_key_out,
    output logic                 o_audio_out,
    input  t_dp_cmd              i_cmd,
    output t_dp_stat             o_stat
);

    localparam int PROD_W  = POT_BITS + WPM_W;
    localparam int NUM_W   = $clog2(UNIT_NUM + 1);
    localparam int DEN_W   = $clog2(WPM_MAX * WPM_FACTOR + 1);

    logic [WPM_W-1:0]    r_max_wpm;
    logic [WPM_W-1:0]    r_min_wpm;
    logic                r_dot;
    logic                r_dash;
    logic [POT_BITS-1:0] r_pot;
    logic                r_map_neg;
    logic [WPM_W-1:0]    r_map_q;
    logic [UNIT_W-1:0]   r_unit;
    logic [TICK_W-1:0]   r_ticks;
    logic                r_tone;
    logic                r_out_valid;
    logic                r_key;
    logic                r_audio;

    logic [WPM_W-1:0]    mag;
    logic [PROD_W-1:0]   prod;
    logic [PROD_W-1:0]   map_sum;
    logic [WPM_W:0]      wpm;
    logic [WPM_W:0]      wpm_sat;
    logic [NUM_W-1:0]    div_num;
    logic [DEN_W-1:0]    div_den;
    logic                div_done;
    logic [NUM_W-1:0]    div_quo;

    always_comb begin
        mag  = (r_min_wpm < r_max_wpm) ? r_max_wpm - r_min_wpm : r_min_wpm - r_max_wpm;
        prod = PROD_W'(r_pot) * PROD_W'(mag);
        // divide by 2^POT_BITS - 1: fold the high part back in once
        map_sum = prod + (prod >> POT_BITS) + PROD_W'(1);
        wpm  = r_map_neg ? {1'b0, r_max_wpm} - {1'b0, r_map_q}
                         : {1'b0, r_max_wpm} + {1'b0, r_map_q};
        wpm_sat = (wpm == '0) ? (WPM_W + 1)'(1) : wpm;
        div_num = NUM_W'(UNIT_NUM);
        div_den = DEN_W'(wpm_sat) * DEN_W'(WPM_FACTOR);
    end

    mpk_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.unit_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    // configuration, keyer state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_wpm   <= RST_MAX_WPM;
            r_min_wpm   <= RST_MIN_WPM;
            r_unit      <= '0;
            r_ticks     <= '0;
            r_tone      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_MAX_WPM: r_max_wpm <= i_cfg_data;
                    CFG_MIN_WPM: r_min_wpm <= i_cfg_data;
                    default: ;
                endcase
            end

            if (i_cmd.unit_latch) begin
                r_unit <= div_quo[UNIT_W-1:0];
            end

            unique case (i_cmd.tick_op)
                TK_LOAD_DOT:  r_ticks <= TICK_W'(r_unit) * TICK_W'(DOT_UNITS);
                TK_LOAD_DASH: r_ticks <= TICK_W'(r_unit) * TICK_W'(DASH_UNITS);
                TK_LOAD_UNIT: r_ticks <= TICK_W'(r_unit);
                TK_DEC:       r_ticks <= r_ticks - TICK_W'(1);
                default: ;
            endcase

            unique case (i_cmd.tone_op)
                TN_CLEAR:  r_tone <= 1'b0;
                TN_TOGGLE: r_tone <= ~r_tone;
                default: ;
            endcase

            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_latch) begin
            r_dot  <= ~i_dot_lever_n;
            r_dash <= ~i_dash_lever_n;
            r_pot  <= POT_BITS'(i_pot_sample);
        end
        if (i_cmd.map_start) begin
            r_map_neg <= r_min_wpm < r_max_wpm;
            r_map_q   <= map_sum[POT_BITS +: WPM_W];
        end
        if (i_cmd.out_load) begin
            r_key   <= i_cmd.out_key;
            r_audio <= i_cmd.out_key & ~r_tone;
        end
    end

    always_comb begin
        o_stat.dot        = r_dot;
        o_stat.dash       = r_dash;
        o_stat.ticks_zero = r_ticks == '0;
        o_stat.ticks_one  = r_ticks == TICK_W'(1);
        o_stat.div_done   = div_done;
        o_stat.out_free   = ~r_out_valid | i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_key_out   = r_key;
    assign o_audio_out = r_audio;

endmodule

>>> sv/mpk_ctrl.sv
// keyer controller: sequences the dot/dash loop of one tick and drives the datapath
// depends on mpk_pkg
module mpk_ctrl
    import mpk_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_STEP,
        S_MAP,
        S_UNIT,
        S_DOT,
        S_EMIT,
        S_EMIT_IDLE
    } t_state;

    typedef enum logic [2:0] {
        KP_CHECK_DOT,
        KP_KEY_DOT,
        KP_GAP_DOT,
        KP_CHECK_DASH,
        KP_KEY_DASH,
        KP_GAP_DASH
    } t_kphase;

    t_state  r_state,  n_state;
    t_kphase r_phase,  n_phase;
    logic    r_dot_free, n_dot_free;
    logic    r_dash_free, n_dash_free;
    t_dp_cmd cmd;

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_dot_free  = r_dot_free;
        n_dash_free = r_dash_free;
        cmd         = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.in_latch = 1'b1;
                    n_dot_free   = 1'b0;
                    n_dash_free  = 1'b0;
                    n_state      = S_STEP;
                end
            end
            S_STEP: begin
                unique case (r_phase)
                    KP_CHECK_DASH: begin
                        if (i_stat.dash) begin
                            n_phase     = KP_KEY_DASH;
                            cmd.tick_op = TK_LOAD_DASH;
                            cmd.tone_op = TN_CLEAR;
                        end else begin
                            n_dash_free = 1'b1;
                            n_phase     = KP_CHECK_DOT;
                            if (r_dot_free) begin
                                n_state = S_EMIT_IDLE;
                            end
                        end
                    end
                    KP_KEY_DOT, KP_KEY_DASH: begin
                        if (i_stat.ticks_zero) begin
                            n_phase     = (r_phase == KP_KEY_DOT) ? KP_GAP_DOT : KP_GAP_DASH;
                            cmd.tick_op = TK_LOAD_UNIT;
                            cmd.tone_op = TN_CLEAR;
                        end else begin
                            n_state = S_EMIT;
                        end
                    end
                    KP_GAP_DOT, KP_GAP_DASH: begin
                        if (i_stat.ticks_zero) begin
                            n_phase     = (r_phase == KP_GAP_DOT) ? KP_CHECK_DASH : KP_CHECK_DOT;
                            cmd.tone_op = TN_CLEAR;
                            if (r_dot_free && r_dash_free) begin
                                n_phase = KP_CHECK_DOT;
                                n_state = S_EMIT_IDLE;
                            end
                        end else begin
                            n_state = S_EMIT;
                        end
                    end
                    default: begin
                        // dot check: fresh unit from the pot first
                        n_phase       = KP_CHECK_DOT;
                        cmd.map_start = 1'b1;
                        n_state       = S_MAP;
                    end
                endcase
            end
            S_MAP: begin
                cmd.unit_start = 1'b1;
                n_state        = S_UNIT;
            end
            S_UNIT: begin
                if (i_stat.div_done) begin
                    cmd.unit_latch = 1'b1;
                    n_state        = S_DOT;
                end
            end
            S_DOT: begin
                n_state = S_STEP;
                if (i_stat.dot) begin
                    n_phase     = KP_KEY_DOT;
                    cmd.tick_op = TK_LOAD_DOT;
                    cmd.tone_op = TN_CLEAR;
                end else begin
                    n_dot_free = 1'b1;
                    n_phase    = KP_CHECK_DASH;
                    if (r_dash_free) begin
                        n_phase = KP_CHECK_DOT;
                        n_state = S_EMIT_IDLE;
                    end
                end
            end
            S_EMIT: begin
                if (i_stat.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                    if (r_phase == KP_KEY_DOT || r_phase == KP_KEY_DASH) begin
                        cmd.out_key = 1'b1;
                        if (i_stat.ticks_one) begin
                            n_phase     = (r_phase == KP_KEY_DOT) ? KP_GAP_DOT : KP_GAP_DASH;
                            cmd.tick_op = TK_LOAD_UNIT;
                            cmd.tone_op = TN_CLEAR;
                        end else begin
                            cmd.tick_op = TK_DEC;
                            cmd.tone_op = TN_TOGGLE;
                        end
                    end else begin
                        cmd.tick_op = TK_DEC;
                        if (i_stat.ticks_one) begin
                            n_phase = (r_phase == KP_GAP_DOT) ? KP_CHECK_DASH : KP_CHECK_DOT;
                        end
                    end
                end
            end
            S_EMIT_IDLE: begin
                if (i_stat.out_free) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= KP_CHECK_DOT;
            r_dot_free  <= 1'b0;
            r_dash_free <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_dot_free  <= n_dot_free;
            r_dash_free <= n_dash_free;
        end
    end

    assign o_in_ready = r_state == S_IDLE;
    assign o_cmd      = cmd;

endmodule

>>> sv/morse_paddle_keyer.sv
// iambic paddle keyer top level: controller plus datapath, one result per 1 ms tick
// depends on mpk_pkg, mpk_ctrl, mpk_dp
//
// channel   | dir | handshake                  | fields
// tick in   | in  | i_in_valid / o_in_ready    | i_dot_lever_n, i_dash_lever_n, i_pot_sample
// result    | out | o_out_valid / i_out_ready  | o_key_out, o_audio_out
// config    | in  | i_cfg_we (no wait)         | i_cfg_idx, i_cfg_data
//
// a tick that reaches the dot check also passes S_MAP, S_UNIT (one pass of the bit-serial
// unit divider, one bit per cycle, NUM_W = 16) and S_DOT before its result is emitted
// any other tick goes only through S_STEP to S_EMIT or S_EMIT_IDLE in the controller
// one tick at a time; o_in_ready rises once the result is in the output register
// a stalled result holds the controller before its next result load
// synchronous active-low reset: no valid result, loop at the dot check, 30/3 wpm (key outputs not reset)
module morse_paddle_keyer
    import mpk_pkg::*;
#(
    parameter int POT_BITS = POT_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [WPM_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic                 i_dot_lever_n,
    input  logic                 i_dash_lever_n,
    input  logic [POT_W-1:0]     i_pot_sample,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_key_out,
    output logic                 o_audio_out
);

    t_dp_cmd  cmd;
    t_dp_stat stat;

    mpk_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    mpk_dp #(
        .POT_BITS (POT_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_dot_lever_n  (i_dot_lever_n),
        .i_dash_lever_n (i_dash_lever_n),
        .i_pot_sample   (i_pot_sample),
        .i_out_ready    (i_out_ready),
        .o_out_valid    (o_out_valid),
        .o_key_out      (o_key_out),
        .o_audio_out    (o_audio_out),
        .i_cmd          (cmd),
        .o_stat         (stat)
    );

endmodule

>>> sv/mpk_checker.sv
// port-level checks for the paddle keyer, bound to the top level
// depends on mpk_pkg and morse_paddle_keyer
module mpk_checker
    import mpk_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_cfg_we,
    input logic [CFG_IDX_W-1:0] i_cfg_idx,
    input logic [WPM_W-1:0]     i_cfg_data,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 i_dot_lever_n,
    input logic                 i_dash_lever_n,
    input logic [POT_W-1:0]     i_pot_sample,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input logic                 o_key_out,
    input logic                 o_audio_out
);

    // sidetone only while keyed, checked while a result is valid
    a_audio_keyed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_key_out || !o_audio_out))
        else $error("sidetone high with key up");

    // one tick in flight: no new transfer right after an input transfer
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after input transfer");

    // a result appears only after a tick was taken
    a_result_after_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(!o_in_ready))
        else $error("result without a tick in progress");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && o_in_ready))
        else $error("outputs not cleared by reset");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_key_out) && $stable(o_audio_out)))
        else $error("stalled result changed");

endmodule

bind morse_paddle_keyer mpk_checker u_mpk_checker (.*);
